>>> rtl/core/cfh_pkg.sv
// Shared types and constants for the compass heading pipeline.
`timescale 1ns / 1ps

package cfh_pkg;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 28;
    localparam int XY_W         = 34;   // |x|,|y| stay below 2^31 after gain
    localparam int ANG_W        = 32;   // binary angle, 2^32 per turn
    localparam int IN_W         = 16;
    localparam int HEAD_W       = 15;
    localparam int SCALE_SHIFT  = 14;   // inputs scaled by 16384
    localparam int PROD_W       = 41;   // 32 x 9 bit product

    // degree constants
    localparam int DEG_QUARTER  = 90;
    localparam int DEG_HALF     = 180;
    localparam int DEG_3QUARTER = 270;
    localparam int DEG_FULL     = 360;

    // prep + one stage per iteration + multiply + round/output
    localparam int PIPE_LATENCY = CORDIC_STEPS + 3;

    localparam logic [ANG_W-1:0] ANG_HALF = 32'h8000_0000;

    // atan(2^-i) in binary angle units
    localparam logic [ANG_W-1:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    // how the heading of an item is settled
    typedef enum logic [2:0] {
        KIND_CORDIC = 3'd0,
        KIND_NONE   = 3'd1,
        KIND_DEG0   = 3'd2,
        KIND_DEG90  = 3'd3,
        KIND_DEG180 = 3'd4,
        KIND_DEG270 = 3'd5
    } kind_t;

    typedef struct packed {
        logic                    valid;
        kind_t                   kind;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic [ANG_W-1:0]        z;
    } vec_t;

endpackage

>>> rtl/core/cfh_prep.sv
// Input stage: special-case sort, half-plane fold and scaling.
`timescale 1ns / 1ps

module cfh_prep
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic signed [cfh_pkg::IN_W-1:0] field_x,
    input  logic signed [cfh_pkg::IN_W-1:0] field_y,
    output cfh_pkg::vec_t                  vec
);

    localparam int XW = cfh_pkg::XY_W;

    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;
    cfh_pkg::vec_t        vec_next;
    cfh_pkg::vec_t        vec_reg;

    always_comb
    begin
        xe = {{(XW-cfh_pkg::IN_W){field_x[cfh_pkg::IN_W-1]}}, field_x};
        ye = {{(XW-cfh_pkg::IN_W){field_y[cfh_pkg::IN_W-1]}}, field_y};
        vec_next       = '0;
        vec_next.valid = accept;
        vec_next.z     = '0;
        // fold left half-plane onto the right, half a turn added
        if (field_x < 0)
        begin
            xe         = -xe;
            ye         = -ye;
            vec_next.z = cfh_pkg::ANG_HALF;
        end
        vec_next.x = xe <<< cfh_pkg::SCALE_SHIFT;
        vec_next.y = ye <<< cfh_pkg::SCALE_SHIFT;

        if (field_x == 0 && field_y == 0)
            vec_next.kind = cfh_pkg::KIND_NONE;
        else if (field_x == 0)
            vec_next.kind = (field_y < 0) ? cfh_pkg::KIND_DEG90 : cfh_pkg::KIND_DEG270;
        else if (field_y == 0)
            vec_next.kind = (field_x > 0) ? cfh_pkg::KIND_DEG0 : cfh_pkg::KIND_DEG180;
        else
            vec_next.kind = cfh_pkg::KIND_CORDIC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vec_reg <= '0;
        else
            vec_reg <= vec_next;
    end

    assign vec = vec_reg;

endmodule

>>> rtl/core/cfh_cordic_stage.sv
// One registered CORDIC vectoring iteration.
`timescale 1ns / 1ps

module cfh_cordic_stage
#(
    parameter int STEP = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfh_pkg::vec_t vec_in,
    output cfh_pkg::vec_t vec_out
);

    cfh_pkg::vec_t vec_next;
    cfh_pkg::vec_t vec_reg;

    always_comb
    begin
        vec_next = vec_in;
        // arithmetic shift is the floor division of the model
        if (vec_in.y > 0)
        begin
            vec_next.x = vec_in.x + (vec_in.y >>> STEP);
            vec_next.y = vec_in.y - (vec_in.x >>> STEP);
            vec_next.z = vec_in.z + cfh_pkg::ATAN_TURNS[STEP];
        end
        else
        begin
            vec_next.x = vec_in.x - (vec_in.y >>> STEP);
            vec_next.y = vec_in.y + (vec_in.x >>> STEP);
            vec_next.z = vec_in.z - cfh_pkg::ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vec_reg <= '0;
        else
            vec_reg <= vec_next;
    end

    assign vec_out = vec_reg;

endmodule

>>> rtl/core/cfh_scale.sv
// Angle to degree units: multiply stage, then round, wrap and output stage.
`timescale 1ns / 1ps

module cfh_scale
#(
    parameter int FRAC_BITS = 6
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfh_pkg::vec_t                vec_in,
    output logic [cfh_pkg::HEAD_W-1:0]   heading,
    output logic                         no_field,
    output logic                         done
);

    localparam int SUM_W   = cfh_pkg::PROD_W + FRAC_BITS + 1;
    localparam int UNITS_W = SUM_W - cfh_pkg::ANG_W;

    localparam logic [UNITS_W-1:0] U_FULL = UNITS_W'(cfh_pkg::DEG_FULL) << FRAC_BITS;
    localparam logic [UNITS_W-1:0] U_90   = UNITS_W'(cfh_pkg::DEG_QUARTER) << FRAC_BITS;
    localparam logic [UNITS_W-1:0] U_180  = UNITS_W'(cfh_pkg::DEG_HALF) << FRAC_BITS;
    localparam logic [UNITS_W-1:0] U_270  = UNITS_W'(cfh_pkg::DEG_3QUARTER) << FRAC_BITS;
    localparam logic [SUM_W-1:0]   HALF_LSB = SUM_W'(cfh_pkg::ANG_HALF);

    // multiply stage
    logic [cfh_pkg::ANG_W-1:0]  h;
    logic [cfh_pkg::PROD_W-1:0] prod_next;
    logic [cfh_pkg::PROD_W-1:0] prod_reg;
    cfh_pkg::kind_t             kind_reg;
    logic                       valid_a_reg;

    // round stage
    logic [SUM_W-1:0]           sum;
    logic [UNITS_W-1:0]         units;
    logic [UNITS_W-1:0]         units_sel;
    logic [cfh_pkg::HEAD_W-1:0] heading_next;
    logic [cfh_pkg::HEAD_W-1:0] heading_reg;
    logic                       no_field_next;
    logic                       no_field_reg;
    logic                       done_reg;

    always_comb
    begin
        h         = '0 - vec_in.z;     // clockwise heading
        prod_next = cfh_pkg::PROD_W'(h) * cfh_pkg::PROD_W'(cfh_pkg::DEG_FULL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else
            valid_a_reg <= vec_in.valid;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        kind_reg <= vec_in.kind;
    end

    always_comb
    begin
        sum   = (SUM_W'(prod_reg) << FRAC_BITS) + HALF_LSB;
        units = sum[SUM_W-1:cfh_pkg::ANG_W];
        if (units >= U_FULL)
            units = units - U_FULL;

        no_field_next = 1'b0;
        case (kind_reg)
            cfh_pkg::KIND_CORDIC: units_sel = units;
            cfh_pkg::KIND_NONE:
            begin
                units_sel     = '0;
                no_field_next = 1'b1;
            end
            cfh_pkg::KIND_DEG0:   units_sel = '0;
            cfh_pkg::KIND_DEG90:  units_sel = U_90;
            cfh_pkg::KIND_DEG180: units_sel = U_180;
            cfh_pkg::KIND_DEG270: units_sel = U_270;
            default:              units_sel = '0;
        endcase
        heading_next = cfh_pkg::HEAD_W'(units_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_a_reg;
    end

    always_ff @(posedge clk)
    begin
        heading_reg  <= heading_next;
        no_field_reg <= no_field_next;
    end

    assign heading  = heading_reg;
    assign no_field = no_field_reg;
    assign done     = done_reg;

endmodule

>>> rtl/core/compass_heading_from_field.sv
// Top level: pipelined compass heading from a horizontal field pair.
`timescale 1ns / 1ps
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+----------------------------------
//  request  | field_x, field_y          | taken on an edge with start=1,
//           |                           | busy=0 (busy is always low)
//  result   | heading, no_field         | done high for one cycle per request
//
//  A request may be issued on every clock; its result passes through the
//  fold/scale stage, 28 CORDIC iterations, multiply and round/wrap.
//  Throughput is one request per clock: the CORDIC chain is fully unrolled.
//  Reset clears the prep and CORDIC registers and every valid bit; requests
//  in flight at reset are dropped. The receiver cannot stall, so the
//  pipeline never holds and busy stays low.
//
module compass_heading_from_field
#(
    parameter int ANGLE_FRACTION_BITS = 6
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [cfh_pkg::IN_W-1:0]  field_x,
    input  logic signed [cfh_pkg::IN_W-1:0]  field_y,
    output logic [cfh_pkg::HEAD_W-1:0]       heading,
    output logic                             no_field,
    output logic                             done
);

    logic          accept;
    // one vector per pipeline boundary of the CORDIC chain
    cfh_pkg::vec_t chain [0:cfh_pkg::CORDIC_STEPS];

    // never stalls: a request is taken on every cycle it is offered
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // special cases are sorted here and ride alongside as a kind code;
    // left half-plane inputs are folded by negation plus half a turn
    cfh_prep u_prep
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .field_x (field_x),
        .field_y (field_y),
        .vec     (chain[0])
    );

    // vectoring: drive y to zero, accumulating the angle in z
    for (genvar i = 0; i < cfh_pkg::CORDIC_STEPS; i++)
    begin : g_step
        cfh_cordic_stage #(.STEP(i)) u_stage
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .vec_in  (chain[i]),
            .vec_out (chain[i+1])
        );
    end

    // negate, scale the binary angle to degree units, round, wrap at 360; special cases take their fixed heading
    cfh_scale #(.FRAC_BITS(ANGLE_FRACTION_BITS)) u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .vec_in   (chain[cfh_pkg::CORDIC_STEPS]),
        .heading  (heading),
        .no_field (no_field),
        .done     (done)
    );

endmodule

>>> rtl/core/cfh_checker.sv
// Port-level checks for the compass heading block, bound to the top level.
`timescale 1ns / 1ps

module cfh_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic signed [cfh_pkg::IN_W-1:0]  field_x,
    input logic signed [cfh_pkg::IN_W-1:0]  field_y,
    input logic [cfh_pkg::HEAD_W-1:0]       heading,
    input logic                             no_field,
    input logic                             done
);

    localparam int LAT   = cfh_pkg::PIPE_LATENCY;
    localparam int CNT_W = $clog2(LAT + 1);

    logic [CNT_W-1:0] since_rst_reg;
    logic [CNT_W-1:0] since_rst_next;
    logic             warm;

    always_comb
    begin
        since_rst_next = since_rst_reg;
        if (since_rst_reg != CNT_W'(LAT))
            since_rst_next = since_rst_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            since_rst_reg <= '0;
        else
            since_rst_reg <= since_rst_next;
    end

    assign warm = (since_rst_reg == CNT_W'(LAT));

    // every request gives exactly one result, and no result comes without a request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> (done == $past(start && !busy, LAT)))
        else $error("result strobe does not match request latency");

    // the no-field flag belongs to an all-zero request
    a_no_field_src: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> ((done && no_field) ==
                  $past(start && !busy && field_x == 0 && field_y == 0, LAT)))
        else $error("no_field flag does not match zero request");

    // an undefined heading is reported as zero
    a_no_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_field) |-> (heading == '0))
        else $error("heading nonzero with no_field set");

    // no results before anything could have been requested
    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (since_rst_reg == '0) |=> !done)
        else $error("result strobe straight after reset");

endmodule

bind compass_heading_from_field cfh_checker u_cfh_checker (.*);

>>> tb/tb.sv
// Self-checking bench for the compass heading pipeline: directed and random field pairs.
`timescale 1ns / 1ps

module tb;

    import cfh_pkg::*;

    // Fraction bits of the heading, kept equal to the DUT parameter.
    localparam int FRAC_BITS  = 6;
    localparam int FULL_UNITS = DEG_FULL << FRAC_BITS;

    // Cycles with no request taken and no result seen before the run is
    // abandoned. The slowest correct stretch is one pipeline latency plus
    // a long sender gap, so this is several times that.
    localparam int WATCHDOG_LIMIT = 500;

    // One expected result. The approx flag marks a heading that came out
    // of the CORDIC path, where one unit of error either way is allowed.
    // The axis and zero cases are exact.
    typedef struct {
        logic [HEAD_W-1:0] heading;
        logic              no_field;
        bit                approx;
    } heading_exp_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [IN_W-1:0]  field_x;
    logic signed [IN_W-1:0]  field_y;
    logic [HEAD_W-1:0]       heading;
    logic                    no_field;
    logic                    done;

    heading_exp_t pending_headings[$];
    int           mismatch_count;
    int           quiet_cycles;
    int           sender_idle_pct;

    compass_heading_from_field #(
        .ANGLE_FRACTION_BITS(FRAC_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .field_x  (field_x),
        .field_y  (field_y),
        .heading  (heading),
        .no_field (no_field),
        .done     (done)
    );

    // 4 ns clock, high then low.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: heading = -atan2(y, x) mod 360, in 1/64 degree units.
    // Axis and origin cases are settled directly; the rest go through a
    // 28-step CORDIC vectoring pass on binary angles (2^32 per turn).
    // ------------------------------------------------------------------
    function automatic heading_exp_t predict_heading(input logic signed [IN_W-1:0] fx,
                                                     input logic signed [IN_W-1:0] fy);
        heading_exp_t  r;
        longint        cx;
        longint        cy;
        longint        nx;
        longint        ny;
        logic [31:0]   ang;
        logic [31:0]   cw;
        logic [63:0]   units;
        int            i;
        r.no_field = 1'b0;
        r.approx   = 1'b0;
        units      = '0;
        if (fx == 0 && fy == 0)
        begin
            r.no_field = 1'b1;
        end
        else if (fx == 0)
        begin
            units = (fy < 0) ? 64'(DEG_QUARTER << FRAC_BITS) : 64'(DEG_3QUARTER << FRAC_BITS);
        end
        else if (fy == 0)
        begin
            units = (fx > 0) ? 64'd0 : 64'(DEG_HALF << FRAC_BITS);
        end
        else
        begin
            r.approx = 1'b1;
            cx  = fx;
            cy  = fy;
            ang = '0;
            // fold the left half-plane over, half a turn added back
            if (cx < 0)
            begin
                cx  = -cx;
                cy  = -cy;
                ang = ANG_HALF;
            end
            cx = cx <<< SCALE_SHIFT;
            cy = cy <<< SCALE_SHIFT;
            for (i = 0; i < CORDIC_STEPS; i++)
            begin
                // arithmetic shift on a signed value is a floor division
                if (cy > 0)
                begin
                    nx  = cx + (cy >>> i);
                    ny  = cy - (cx >>> i);
                    ang = ang + ATAN_TURNS[i];
                end
                else
                begin
                    nx  = cx - (cy >>> i);
                    ny  = cy + (cx >>> i);
                    ang = ang - ATAN_TURNS[i];
                end
                cx = nx;
                cy = ny;
            end
            cw    = 32'd0 - ang;
            units = (((64'(cw) * 64'(DEG_FULL)) << FRAC_BITS) + 64'h8000_0000) >> 32;
            if (units >= 64'(FULL_UNITS))
                units = units - 64'(FULL_UNITS);
        end
        r.heading = units[HEAD_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("tb: mismatch on %s: got %0d, want %0d, at %0t", what, got, want_v, $time);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Request side. Called at a falling edge; returns at a falling edge
    // with start still high, so back-to-back requests never drop start.
    // Each cycle before the request is idle with the set percentage.
    // ------------------------------------------------------------------
    task automatic send_field(input logic signed [IN_W-1:0] fx,
                              input logic signed [IN_W-1:0] fy);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            // idle cycle: start low, junk on the field ports
            start   <= 1'b0;
            field_x <= IN_W'($urandom());
            field_y <= IN_W'($urandom());
            @(negedge clk);
        end
        start   <= 1'b1;
        field_x <= fx;
        field_y <= fy;
        do
            @(posedge clk);
        while (busy);
        pending_headings.push_back(predict_heading(fx, fy));
        @(negedge clk);
    endtask

    // Stop sending and hold off until every expected result is back.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_headings.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: every done cycle is checked against the oldest
    // expectation. Also runs the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        heading_exp_t want;
        int           diff;
        bit           heading_ok;
        if (done)
        begin
            if (pending_headings.size() == 0)
            begin
                report_mismatch("result with no request waiting", int'(heading), 0);
            end
            else
            begin
                want = pending_headings.pop_front();
                if (want.approx)
                begin
                    // one unit either way, wrapping round the full turn
                    diff = (int'(heading) - int'(want.heading) + FULL_UNITS) % FULL_UNITS;
                    heading_ok = (int'(heading) < FULL_UNITS)
                                 && (diff == 0 || diff == 1 || diff == FULL_UNITS - 1);
                end
                else
                begin
                    heading_ok = (heading == want.heading);
                end
                if (!heading_ok)
                    report_mismatch("heading", int'(heading), int'(want.heading));
                if (no_field !== want.no_field)
                    report_mismatch("no_field", int'(no_field), int'(want.no_field));
            end
        end

        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Origin and the four axis directions, each exact.
    task automatic test_axes_and_origin();
        send_field(16'sd0, 16'sd0);
        send_field(16'sd0, -16'sd5);
        send_field(16'sd0, 16'sd7);
        send_field(16'sd9, 16'sd0);
        send_field(-16'sd9, 16'sd0);
        send_field(16'sd0, -16'sd32768);
        send_field(16'sd0, 16'sd32767);
        send_field(16'sd32767, 16'sd0);
        send_field(-16'sd32768, 16'sd0);
    endtask

    // Corners of the input range, unit vectors, and the near-zero heading
    // that rounds up to a full turn and must come back as 0.
    task automatic test_field_extremes();
        send_field(16'sd32767, 16'sd32767);
        send_field(-16'sd32768, -16'sd32768);
        send_field(16'sd32767, -16'sd32768);
        send_field(-16'sd32768, 16'sd32767);
        send_field(16'sd1, 16'sd1);
        send_field(-16'sd1, 16'sd1);
        send_field(16'sd1, -16'sd1);
        send_field(-16'sd1, -16'sd1);
        send_field(16'sd1, -16'sd32768);
        send_field(-16'sd32768, 16'sd1);
        send_field(16'sd32767, 16'sd1);
        send_field(16'sd32767, -16'sd1);
        send_field(-16'sd1, -16'sd32768);
    endtask

    // Random field pairs, weighted towards the awkward regions: small
    // vectors, one component zero or tiny, corners and diagonals.
    task automatic test_random_fields(input int n_items);
        logic signed [IN_W-1:0] fx;
        logic signed [IN_W-1:0] fy;
        logic signed [IN_W-1:0] corner_vals [5];
        int                     k;
        corner_vals = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
        for (k = 0; k < n_items; k++)
        begin
            fx = IN_W'($urandom());
            fy = IN_W'($urandom());
            case ($urandom_range(0, 9))
                5:
                begin
                    fx = IN_W'($urandom_range(0, 6) - 3);
                    fy = IN_W'($urandom_range(0, 6) - 3);
                end
                6:
                begin
                    if ($urandom_range(0, 1)) fx = '0;
                    else                      fy = '0;
                end
                7:
                begin
                    if ($urandom_range(0, 1)) fx = IN_W'($urandom_range(0, 4) - 2);
                    else                      fy = IN_W'($urandom_range(0, 4) - 2);
                end
                8:
                begin
                    fx = corner_vals[$urandom_range(0, 4)];
                    fy = corner_vals[$urandom_range(0, 4)];
                end
                9:
                begin
                    fy = $urandom_range(0, 1) ? fx : -fx;
                end
                default: ;
            endcase
            send_field(fx, fy);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        mismatch_count  = 0;
        quiet_cycles    = 0;
        sender_idle_pct = 13;
        rst_n   = 1'b0;
        start   = 1'b0;
        field_x = '0;
        field_y = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_axes_and_origin();
        test_field_extremes();

        // light gaps from the sender
        test_random_fields(150);
        // hold off until the pipeline is empty before changing pace
        drain_results();
        @(negedge clk);

        // heavy gaps from the sender
        sender_idle_pct = 80;
        test_random_fields(150);

        // requests on every clock
        sender_idle_pct = 0;
        test_random_fields(150);

        drain_results();
        repeat (PIPE_LATENCY + 5) @(negedge clk);

        if (pending_headings.size() != 0)
            report_mismatch("results never returned", 0, pending_headings.size());

        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/core/cfh_pkg.sv
rtl/core/cfh_prep.sv
rtl/core/cfh_cordic_stage.sv
rtl/core/cfh_scale.sv
rtl/core/compass_heading_from_field.sv
rtl/core/cfh_checker.sv
tb/tb.sv
